@@ rtl/cww_pkg.sv @@
// ----------------------------------------------------------------------------
// cww_pkg
// Shared types, constants and rounding helpers for the contact wrench weight
// block.
// ----------------------------------------------------------------------------
package cww_pkg;

  localparam int FracBits = 12;   // fraction bits of values and weight
  localparam int MuFrac   = 12;   // fraction bits of the friction coefficient
  localparam int ValW     = 16;
  localparam int AccW     = 70;
  localparam int MulAW    = 36;
  localparam int MulBW    = 33;
  localparam int ProdW    = MulAW + MulBW;
  localparam int WeightW  = 31;
  localparam int RowW     = 3;
  localparam int NumRows  = 6;
  localparam int RowDataW = NumRows * ValW;

  localparam logic [WeightW-1:0] WeightMax = '1;

  localparam logic signed [AccW-1:0] HalfF  = AccW'(1) << (FracBits - 1);
  localparam logic signed [AccW-1:0] Half2F = AccW'(1) << (2 * FracBits - 1);

  typedef enum logic [1:0] {
    OpLoadMetric = 2'd0,
    OpLoadDir    = 2'd1,
    OpCompute    = 2'd2,
    OpUnused     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StMat,
    StVec,
    StSqrt,
    StCone,
    StTan,
    StDiv,
    StDivEnd,
    StOut
  } state_e;

  // Round half up at scale F or 2F, then saturate to signed 32 bits.
  function automatic logic signed [31:0] rnd_sat(input logic signed [AccW-1:0] x,
                                                 input logic two_f);
    logic signed [AccW-1:0] s;
    begin
      s = x + (two_f ? Half2F : HalfF);
      s = two_f ? (s >>> (2 * FracBits)) : (s >>> FracBits);
      if (&s[AccW-1:31] || ~|s[AccW-1:31]) begin
        rnd_sat = s[31:0];
      end else if (s[AccW-1]) begin
        rnd_sat = 32'sh8000_0000;
      end else begin
        rnd_sat = 32'sh7fff_ffff;
      end
    end
  endfunction

endpackage

@@ rtl/cww_ram.sv @@
// ----------------------------------------------------------------------------
// cww_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cww_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/contact_wrench_weight_top.sv @@
// ----------------------------------------------------------------------------
// contact_wrench_weight_top
// Contact wrench weight: u = M^T d, g = u_top + u_bot x p, normal and
// tangential parts against n, friction cone test and weight, all on one
// shared multiplier plus bit-serial square root and divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_ready_o   opcode, row_index, value_0..5
//  result    out        out_valid_o/out_ready_i grasp_weight, inside_cone
//  config    in         cfg_we_i                cfg_wdata_i (friction coeff)
//
// Load items are taken while the block stays idle. A compute item keeps the
// input busy through the matrix product, 15 multiply steps, 32 square-root
// steps, one cone test, then either one tangential weight step or 32
// divider steps plus one end step, and one output step. The shared 36x33
// multiplier and the one-bit-per-cycle root and divider carry these steps.
// Reset clears control and sets the friction coefficient to 0.5. A
// finished result waits in the output register; a new item is taken
// meanwhile, and its result waits until that register is free.
// ----------------------------------------------------------------------------
module contact_wrench_weight_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [2:0]                    row_index_i,
  input  logic signed [cww_pkg::ValW-1:0] value_0_i,
  input  logic signed [cww_pkg::ValW-1:0] value_1_i,
  input  logic signed [cww_pkg::ValW-1:0] value_2_i,
  input  logic signed [cww_pkg::ValW-1:0] value_3_i,
  input  logic signed [cww_pkg::ValW-1:0] value_4_i,
  input  logic signed [cww_pkg::ValW-1:0] value_5_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cww_pkg::WeightW-1:0]   grasp_weight_o,
  output logic                          inside_cone_o
);

  import cww_pkg::*;

  state_e state_q, state_d;

  logic [15:0] mu_q;
  logic signed [ValW-1:0] dir_q [NumRows];
  logic signed [ValW-1:0] pv_q  [NumRows];
  logic signed [ValW-1:0] vin   [NumRows];

  logic signed [MulAW-1:0] u_q [NumRows];
  logic signed [31:0] g_q [3];
  logic signed [31:0] wperp_q, h_q;
  logic signed [AccW-1:0] acc_q;
  logic [63:0] sq_q, x_q, r_q, bit_q;
  logic [31:0] wpara_q, rem_q, quot_q;
  logic ovf_q, cone_q;
  logic [WeightW-1:0] weight_q;
  logic [3:0] step_q;
  logic [4:0] cnt_q;

  logic [2:0] row_q, col_q, rd_row_q, rd_col_q;
  logic issue_done_q, rd_vld_q;

  logic out_valid_q, inside_cone_q;
  logic [WeightW-1:0] grasp_weight_q;

  logic in_acc;
  logic [RowDataW-1:0] ram_wdata, ram_rdata;
  logic ram_we;

  // shared multiplier
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0] base, sum;
  logic use_acc, two_f;
  logic signed [31:0] rs;

  assign vin[0] = value_0_i;
  assign vin[1] = value_1_i;
  assign vin[2] = value_2_i;
  assign vin[3] = value_3_i;
  assign vin[4] = value_4_i;
  assign vin[5] = value_5_i;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  assign ram_we    = in_acc && (op_e'(opcode_i) == OpLoadMetric) &&
                     (row_index_i < RowW'(NumRows));
  assign ram_wdata = {value_5_i, value_4_i, value_3_i, value_2_i, value_1_i, value_0_i};

  cww_ram #(
    .Width (RowDataW),
    .Depth (NumRows)
  ) u_metric_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_index_i),
    .wdata_i (ram_wdata),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  // Operand selection per phase and step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    base    = '0;
    use_acc = 1'b1;
    two_f   = 1'b0;
    unique case (state_q)
      StMat: begin
        mul_a = MulAW'(dir_q[rd_row_q]);
        mul_b = MulBW'($signed(ram_rdata[rd_col_q*ValW +: ValW]));
      end
      StVec: begin
        unique case (step_q)
          4'd0: begin
            mul_a = u_q[4]; mul_b = MulBW'(pv_q[2]);
            use_acc = 1'b0; base = AccW'(u_q[0]) <<< FracBits;
          end
          4'd1: begin mul_a = u_q[5]; mul_b = -MulBW'(pv_q[1]); two_f = 1'b1; end
          4'd2: begin
            mul_a = u_q[5]; mul_b = MulBW'(pv_q[0]);
            use_acc = 1'b0; base = AccW'(u_q[1]) <<< FracBits;
          end
          4'd3: begin mul_a = u_q[3]; mul_b = -MulBW'(pv_q[2]); two_f = 1'b1; end
          4'd4: begin
            mul_a = u_q[3]; mul_b = MulBW'(pv_q[1]);
            use_acc = 1'b0; base = AccW'(u_q[2]) <<< FracBits;
          end
          4'd5: begin mul_a = u_q[4]; mul_b = -MulBW'(pv_q[0]); two_f = 1'b1; end
          4'd6: begin
            mul_a = MulAW'(g_q[0]); mul_b = MulBW'(pv_q[3]); use_acc = 1'b0;
          end
          4'd7: begin mul_a = MulAW'(g_q[1]); mul_b = MulBW'(pv_q[4]); end
          4'd8: begin mul_a = MulAW'(g_q[2]); mul_b = MulBW'(pv_q[5]); end
          4'd9, 4'd11, 4'd13: begin
            mul_a   = MulAW'(wperp_q);
            use_acc = 1'b0;
            unique case (step_q)
              4'd9:    begin mul_b = -MulBW'(pv_q[3]); base = AccW'(g_q[0]) <<< FracBits; end
              4'd11:   begin mul_b = -MulBW'(pv_q[4]); base = AccW'(g_q[1]) <<< FracBits; end
              default: begin mul_b = -MulBW'(pv_q[5]); base = AccW'(g_q[2]) <<< FracBits; end
            endcase
          end
          4'd10, 4'd12, 4'd14: begin
            mul_a = MulAW'(h_q); mul_b = MulBW'(h_q); use_acc = 1'b0;
          end
          default: ;
        endcase
      end
      StCone: begin
        mul_a = MulAW'(wperp_q);
        mul_b = MulBW'({1'b0, mu_q});
      end
      StTan: begin
        mul_a = MulAW'({1'b0, wpara_q});
        mul_b = MulBW'({1'b0, mu_q});
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = (use_acc ? acc_q : base) + AccW'(prod);
  assign rs   = rnd_sat(sum, two_f);

  // Square root step
  logic [64:0] rb_sum;
  assign rb_sum = {1'b0, r_q} + {1'b0, bit_q};

  // Divider step
  logic [31:0] trial;
  assign trial = {rem_q[30:0], sq_q[63]};

  // Branch two weight
  logic signed [AccW-1:0] tan_t, tan_w;
  logic signed [ProdW-1:0] cone_rhs;
  logic [32:0] div_w;
  assign tan_t    = (AccW'(prod) + AccW'(1 << (MuFrac - 1))) >>> MuFrac;
  assign tan_w    = AccW'(wperp_q) + tan_t;
  assign cone_rhs = ProdW'({wpara_q, {MuFrac{1'b0}}});
  assign div_w    = {1'b0, wperp_q} + {1'b0, quot_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_acc && op_e'(opcode_i) == OpCompute) state_d = StMat;
      StMat:    if (rd_vld_q && rd_row_q == 3'd5 && rd_col_q == 3'd5) state_d = StVec;
      StVec:    if (step_q == 4'd14) state_d = StSqrt;
      StSqrt:   if (cnt_q == 5'd31) state_d = StCone;
      StCone:   state_d = (prod > cone_rhs) ? StDiv : StTan;
      StTan:    state_d = StOut;
      StDiv:    if (cnt_q == 5'd31) state_d = StDivEnd;
      StDivEnd: state_d = StOut;
      StOut:    if (!out_valid_q || out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      mu_q          <= 16'd2048;
      out_valid_q   <= 1'b0;
      step_q        <= '0;
      cnt_q         <= '0;
      row_q         <= '0;
      col_q         <= '0;
      issue_done_q  <= 1'b0;
      rd_vld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mu_q <= cfg_wdata_i;
      end
      if (state_q == StOut && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      step_q <= (state_q == StVec) ? step_q + 4'd1 : '0;
      cnt_q  <= (state_q == StSqrt || state_q == StDiv) ? cnt_q + 5'd1 : '0;
      if (state_q == StMat) begin
        rd_vld_q <= !issue_done_q;
        if (!issue_done_q) begin
          if (row_q == 3'd5) begin
            row_q <= '0;
            col_q <= col_q + 3'd1;
            if (col_q == 3'd5) issue_done_q <= 1'b1;
          end else begin
            row_q <= row_q + 3'd1;
          end
        end
      end else begin
        rd_vld_q     <= 1'b0;
        row_q        <= '0;
        col_q        <= '0;
        issue_done_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_row_q <= row_q;
    rd_col_q <= col_q;
    if (in_acc && op_e'(opcode_i) == OpLoadDir) begin
      for (int i = 0; i < NumRows; i++) dir_q[i] <= vin[i];
    end
    if (in_acc && op_e'(opcode_i) == OpCompute) begin
      for (int i = 0; i < NumRows; i++) pv_q[i] <= vin[i];
      acc_q <= '0;
    end
    unique case (state_q)
      StMat: begin
        if (rd_vld_q) begin
          if (rd_row_q == 3'd5) begin
            u_q[rd_col_q] <= sum[MulAW-1:0];
            acc_q         <= '0;
          end else begin
            acc_q <= sum;
          end
        end
      end
      StVec: begin
        unique case (step_q)
          4'd1:  g_q[0] <= rs;
          4'd3:  g_q[1] <= rs;
          4'd5:  g_q[2] <= rs;
          4'd8:  wperp_q <= rs;
          4'd9, 4'd11, 4'd13: h_q <= rs;
          4'd10: sq_q <= 64'(prod);
          4'd12, 4'd14: sq_q <= sq_q + 64'(prod);
          default: acc_q <= sum;
        endcase
        if (step_q == 4'd14) begin
          x_q   <= sq_q + 64'(prod);
          r_q   <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
        end
      end
      StSqrt: begin
        if ({1'b0, x_q} >= rb_sum) begin
          x_q <= x_q - rb_sum[63:0];
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_q == 5'd31) begin
          wpara_q <= ({1'b0, x_q} >= rb_sum) ? 32'((r_q >> 1) + bit_q) : 32'(r_q >> 1);
        end
      end
      StCone: begin
        cone_q <= (prod > cone_rhs);
        rem_q  <= sq_q[63:32];
        sq_q   <= {sq_q[31:0], 32'd0};
        ovf_q  <= (sq_q >= {wperp_q, 32'd0});
      end
      StTan: begin
        if (tan_w < 0) begin
          weight_q <= '0;
        end else if (|tan_w[AccW-1:WeightW]) begin
          weight_q <= WeightMax;
        end else begin
          weight_q <= tan_w[WeightW-1:0];
        end
      end
      StDiv: begin
        sq_q <= {sq_q[62:0], 1'b0};
        if (trial >= wperp_q) begin
          rem_q  <= trial - wperp_q;
          quot_q <= {quot_q[30:0], 1'b1};
        end else begin
          rem_q  <= trial;
          quot_q <= {quot_q[30:0], 1'b0};
        end
      end
      StDivEnd: begin
        weight_q <= (ovf_q || div_w[32:31] != 2'b00) ? WeightMax : div_w[WeightW-1:0];
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          grasp_weight_q <= weight_q;
          inside_cone_q  <= cone_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign grasp_weight_o = grasp_weight_q;
  assign inside_cone_o  = inside_cone_q;

  // A taken cone branch always has a positive normal part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> wperp_q > 0)
    else $error("divider running with non-positive normal part");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q != 5'd0 && !ovf_q) |-> rem_q < wperp_q)
    else $error("divider remainder out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && (!out_valid_q || out_ready_i) && cone_q) |=>
      (out_valid_o && grasp_weight_o != '0))
    else $error("cone result with zero weight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_e'(opcode_i) == OpCompute) |=> state_q == StMat)
    else $error("compute transaction did not start the matrix product");

endmodule
